FILE: design/sflc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sflc_pkg: shared types and codes for the sorted free list coalescer
// Operation and status codes, cell command type and control state type.
// ----------------------------------------------------------------------------
package sflc_pkg;

   localparam int OPCODE_BITS    = 2;
   localparam int FIELD_BITS     = 32;
   localparam int STATUS_BITS    = 2;
   localparam int COUNT_OUT_BITS = 5;
   localparam int JOINS_OUT_BITS = 4;

   localparam logic [OPCODE_BITS-1:0] OP_INSERT   = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_DELETE   = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_COALESCE = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_MISSING = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_SHIFT,
      CELL_PLACE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        valid;
      logic        wsel;
      logic        prev_lt;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_COAL,
      FSM_PLACE
   } fsm_state_type;

endpackage
`default_nettype wire

FILE: design/sflc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sflc_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sflc_req_if;
   import sflc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [OPCODE_BITS-1:0] opcode;
   logic [FIELD_BITS-1:0]  block_start;
   logic [FIELD_BITS-1:0]  block_size;
   modport source (output valid, opcode, block_start, block_size, input ready);
   modport sink   (input valid, opcode, block_start, block_size, output ready);
endinterface

interface sflc_rsp_if;
   import sflc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [STATUS_BITS-1:0]    status;
   logic [COUNT_OUT_BITS-1:0] free_count;
   logic [JOINS_OUT_BITS-1:0] joins_made;
   modport source (output valid, status, free_count, joins_made, input ready);
   modport sink   (input valid, status, free_count, joins_made, output ready);
endinterface
`default_nettype wire

FILE: design/sflc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sflc_cell: one entry of the ordered free block chain
// Holds a start and size; shifts from either neighbor or loads a new block.
// ----------------------------------------------------------------------------
module sflc_cell #(
   parameter int ADDR_BITS = 32
) (
   input  wire                       clock,
   input  sflc_pkg::cell_ctl_type    ctl,
   input  wire  [ADDR_BITS-1:0]      key_start,
   input  wire  [ADDR_BITS-1:0]      key_size,
   input  wire  [ADDR_BITS-1:0]      prev_start,
   input  wire  [ADDR_BITS-1:0]      prev_size,
   input  wire  [ADDR_BITS-1:0]      next_start,
   input  wire  [ADDR_BITS-1:0]      next_size,
   output logic [ADDR_BITS-1:0]      cell_start,
   output logic [ADDR_BITS-1:0]      cell_size,
   output logic                      lt,
   output logic                      eq
);
   import sflc_pkg::*;

   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic [ADDR_BITS-1:0] size_ff, size_in;

   assign lt = ctl.valid && (start_ff < key_start);
   assign eq = ctl.valid && (start_ff == key_start);

   always_comb begin
      start_in = start_ff;
      size_in  = size_ff;
      unique case (ctl.op)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            if (!lt) begin
               if (ctl.prev_lt) begin
                  start_in = key_start;
                  size_in  = key_size;
               end else begin
                  start_in = prev_start;
                  size_in  = prev_size;
               end
            end
         end
         CELL_DELETE: begin
            if (!lt) begin
               start_in = next_start;
               size_in  = next_size;
            end
         end
         CELL_SHIFT: begin
            if (ctl.wsel) begin
               start_in = key_start;
               size_in  = key_size;
            end else begin
               start_in = next_start;
               size_in  = next_size;
            end
         end
         CELL_PLACE: begin
            if (ctl.wsel) begin
               start_in = key_start;
               size_in  = key_size;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      size_ff  <= size_in;
   end

   assign cell_start = start_ff;
   assign cell_size  = size_ff;

endmodule
`default_nettype wire

FILE: design/sorted_free_list_coalescer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_free_list_coalescer_top: address-ordered free block table
// Insert, delete by start and a coalescing pass over a chain of cells.
// ----------------------------------------------------------------------------
// Insert, delete and no-op: result registered on the output, or in the pending slot while the output is busy.
// Coalesce on N >= 2 entries: one entry popped from the head of the chain per
// cycle plus a final placement; fewer entries return a result without a pass.
// A result waiting on the output does not block the next transfer (one slot).
// Reset (synchronous) empties the table; entry contents are not cleared.
module sorted_free_list_coalescer_top #(
   parameter int ENTRIES   = 16,
   parameter int ADDR_BITS = 32
) (
   input wire          clock,
   input wire          reset,
   sflc_req_if.sink    req_bus,
   sflc_rsp_if.source  rsp_bus
);
   import sflc_pkg::*;

   localparam int IDX_BITS = $clog2(ENTRIES);
   localparam int CNT_BITS = $clog2(ENTRIES + 1);

   logic [ADDR_BITS-1:0] cell_start [ENTRIES];
   logic [ADDR_BITS-1:0] cell_size  [ENTRIES];
   logic [ENTRIES-1:0]   cell_lt;
   logic [ENTRIES-1:0]   cell_eq;

   fsm_state_type        state_ff, state_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [IDX_BITS-1:0]  rem_ff, rem_in;
   logic [IDX_BITS-1:0]  tail_ff, tail_in;
   logic [IDX_BITS-1:0]  joins_ff, joins_in;
   logic [ADDR_BITS-1:0] acc_start_ff, acc_start_in;
   logic [ADDR_BITS-1:0] acc_size_ff, acc_size_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]    rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic [JOINS_OUT_BITS-1:0] rsp_joins_ff, rsp_joins_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic [STATUS_BITS-1:0]    pend_status_ff, pend_status_in;
   logic [COUNT_OUT_BITS-1:0] pend_count_ff, pend_count_in;
   logic [JOINS_OUT_BITS-1:0] pend_joins_ff, pend_joins_in;

   logic                      res_valid;
   logic [STATUS_BITS-1:0]    res_status;
   logic [IDX_BITS-1:0]       res_joins;
   logic [COUNT_OUT_BITS-1:0] res_count;
   logic [CNT_BITS+COUNT_OUT_BITS-1:0] count_wide;
   logic [IDX_BITS+JOINS_OUT_BITS-1:0] joins_wide;

   cell_op_type          cell_op;
   logic                 wsel_en;
   logic [IDX_BITS-1:0]  wsel_idx;
   logic                 use_acc;
   logic [ADDR_BITS-1:0] key_start, key_size;
   logic [ADDR_BITS-1:0] req_start, req_size;
   logic [ADDR_BITS+FIELD_BITS-1:0] start_wide, size_wide;

   logic                 accept;
   logic                 full, found, touch;
   logic [ADDR_BITS:0]   end_sum, size_sum;
   logic [ADDR_BITS-1:0] merged_size;

   assign start_wide = {{ADDR_BITS{1'b0}}, req_bus.block_start};
   assign size_wide  = {{ADDR_BITS{1'b0}}, req_bus.block_size};
   assign req_start  = start_wide[ADDR_BITS-1:0];
   assign req_size   = size_wide[ADDR_BITS-1:0];

   assign key_start = use_acc ? acc_start_ff : req_start;
   assign key_size  = use_acc ? acc_size_ff  : req_size;

   assign full  = (count_ff == CNT_BITS'(ENTRIES));
   assign found = |cell_eq;

   assign end_sum     = {1'b0, acc_start_ff} + {1'b0, acc_size_ff};
   assign touch       = (end_sum == {1'b0, cell_start[0]});
   assign size_sum    = {1'b0, acc_size_ff} + {1'b0, cell_size[0]};
   assign merged_size = size_sum[ADDR_BITS] ? '1 : size_sum[ADDR_BITS-1:0];

   assign req_bus.ready = (state_ff == FSM_IDLE) && !pend_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      cell_ctl_type         ctl;
      logic                 prev_lt;
      logic [ADDR_BITS-1:0] prev_start, prev_size, next_start, next_size;

      if (i == 0) begin : g_first
         assign prev_lt    = 1'b1;
         assign prev_start = key_start;
         assign prev_size  = key_size;
      end else begin : g_mid
         assign prev_lt    = cell_lt[i-1];
         assign prev_start = cell_start[i-1];
         assign prev_size  = cell_size[i-1];
      end

      if (i == ENTRIES - 1) begin : g_last
         assign next_start = cell_start[i];
         assign next_size  = cell_size[i];
      end else begin : g_inner
         assign next_start = cell_start[i+1];
         assign next_size  = cell_size[i+1];
      end

      assign ctl = '{op:      cell_op,
                     valid:   (CNT_BITS'(i) < count_ff),
                     wsel:    wsel_en && (IDX_BITS'(i) == wsel_idx),
                     prev_lt: prev_lt};

      sflc_cell #(
         .ADDR_BITS (ADDR_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .key_start  (key_start),
         .key_size   (key_size),
         .prev_start (prev_start),
         .prev_size  (prev_size),
         .next_start (next_start),
         .next_size  (next_size),
         .cell_start (cell_start[i]),
         .cell_size  (cell_size[i]),
         .lt         (cell_lt[i]),
         .eq         (cell_eq[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      tail_in      = tail_ff;
      joins_in     = joins_ff;
      acc_start_in = acc_start_ff;
      acc_size_in  = acc_size_ff;
      cell_op      = CELL_HOLD;
      wsel_en      = 1'b0;
      wsel_idx     = '0;
      use_acc      = 1'b0;
      res_valid    = 1'b0;
      res_status   = ST_OK;
      res_joins    = '0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               unique case (req_bus.opcode)
                  OP_INSERT: begin
                     res_valid = 1'b1;
                     if (full) begin
                        res_status = ST_FULL;
                     end else begin
                        cell_op  = CELL_INSERT;
                        count_in = count_ff + CNT_BITS'(1);
                     end
                  end
                  OP_DELETE: begin
                     res_valid = 1'b1;
                     if (found) begin
                        cell_op  = CELL_DELETE;
                        count_in = count_ff - CNT_BITS'(1);
                     end else begin
                        res_status = ST_MISSING;
                     end
                  end
                  OP_COALESCE: begin
                     if (count_ff < CNT_BITS'(2)) begin
                        res_valid = 1'b1;
                     end else begin
                        cell_op      = CELL_SHIFT;
                        acc_start_in = cell_start[0];
                        acc_size_in  = cell_size[0];
                        rem_in       = IDX_BITS'(count_ff - CNT_BITS'(1));
                        tail_in      = IDX_BITS'(count_ff - CNT_BITS'(1));
                        joins_in     = '0;
                        state_in     = FSM_COAL;
                     end
                  end
                  default: begin
                     res_valid = 1'b1;
                  end
               endcase
            end
         end
         FSM_COAL: begin
            cell_op = CELL_SHIFT;
            use_acc = 1'b1;
            if (touch) begin
               acc_size_in = merged_size;
               tail_in     = tail_ff - IDX_BITS'(1);
               joins_in    = joins_ff + IDX_BITS'(1);
            end else begin
               wsel_en      = 1'b1;
               wsel_idx     = tail_ff - IDX_BITS'(1);
               acc_start_in = cell_start[0];
               acc_size_in  = cell_size[0];
            end
            rem_in = rem_ff - IDX_BITS'(1);
            if (rem_ff == IDX_BITS'(1)) begin
               state_in = FSM_PLACE;
            end
         end
         FSM_PLACE: begin
            cell_op   = CELL_PLACE;
            use_acc   = 1'b1;
            wsel_en   = 1'b1;
            wsel_idx  = tail_ff;
            count_in  = CNT_BITS'(tail_ff) + CNT_BITS'(1);
            res_valid = 1'b1;
            res_joins = joins_ff;
            state_in  = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign count_wide = {{COUNT_OUT_BITS{1'b0}}, count_in};
   assign joins_wide = {{JOINS_OUT_BITS{1'b0}}, res_joins};
   assign res_count  = count_wide[COUNT_OUT_BITS-1:0];

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_joins_in   = rsp_joins_ff;
      pend_valid_in  = pend_valid_ff;
      pend_status_in = pend_status_ff;
      pend_count_in  = pend_count_ff;
      pend_joins_in  = pend_joins_ff;
      if (!rsp_valid_ff || rsp_bus.ready) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = pend_status_ff;
            rsp_count_in  = pend_count_ff;
            rsp_joins_in  = pend_joins_ff;
            pend_valid_in = 1'b0;
         end else begin
            rsp_valid_in  = res_valid;
            rsp_status_in = res_status;
            rsp_count_in  = res_count;
            rsp_joins_in  = joins_wide[JOINS_OUT_BITS-1:0];
         end
      end else if (res_valid) begin
         pend_valid_in  = 1'b1;
         pend_status_in = res_status;
         pend_count_in  = res_count;
         pend_joins_in  = joins_wide[JOINS_OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff         <= rem_in;
      tail_ff        <= tail_in;
      joins_ff       <= joins_in;
      acc_start_ff   <= acc_start_in;
      acc_size_ff    <= acc_size_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_joins_ff   <= rsp_joins_in;
      pend_status_ff <= pend_status_in;
      pend_count_ff  <= pend_count_in;
      pend_joins_ff  <= pend_joins_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.free_count = rsp_count_ff;
   assign rsp_bus.joins_made = rsp_joins_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(ENTRIES))
      else $error("entry count beyond table depth");

   a_pend_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("pending result without an occupied output");

   a_coal_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_COAL) |-> (rem_ff != '0))
      else $error("coalesce pass with nothing left to pop");

   a_tail_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != FSM_IDLE) |-> (CNT_BITS'(tail_ff) < count_ff))
      else $error("coalesce write pointer outside the table");

   a_coal_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_PLACE) |=> (state_ff == FSM_IDLE) && rsp_valid_ff)
      else $error("coalesce pass ended without a result");

endmodule
`default_nettype wire

FILE: tb/sorted_free_list_coalescer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_free_list_coalescer_top_test: free block table checker
// Walks a short table of directed operations, then random episodes of
// adjacent block chains, deletes and noise. Each response transfer is checked
// field by field against an in-order queue of predicted responses, with
// random idle gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module sorted_free_list_coalescer_top_test;
   import sflc_pkg::*;

   localparam int TABLE_DEPTH  = 16;
   localparam int HALF_PERIOD  = 10;
   localparam int RANDOM_ITEMS = 1800;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 40;
   localparam int DRAIN_EVERY  = 450;
   localparam logic [OPCODE_BITS-1:0] OP_NOP = 2'd3;

   typedef struct packed {
      logic [STATUS_BITS-1:0]    status;
      logic [COUNT_OUT_BITS-1:0] count;
      logic [JOINS_OUT_BITS-1:0] joins;
   } free_rsp_type;

   typedef struct {
      logic [OPCODE_BITS-1:0] op;
      logic [FIELD_BITS-1:0]  start;
      logic [FIELD_BITS-1:0]  size;
      bit                     typed;
      free_rsp_type           rsp;
   } plan_row_type;

   logic clock;
   logic reset;

   sflc_req_if req_bus ();
   sflc_rsp_if rsp_bus ();

   sorted_free_list_coalescer_top #(
      .ENTRIES   (TABLE_DEPTH),
      .ADDR_BITS (FIELD_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // free block table as the block should hold it
   logic [FIELD_BITS-1:0] free_start [TABLE_DEPTH];
   logic [FIELD_BITS-1:0] free_size  [TABLE_DEPTH];
   int                    free_cnt;

   free_rsp_type rsp_due [$];
   plan_row_type plan [$];
   bit           failed;
   int           items_sent;
   int           idle_cycles;
   bit           send_burst;
   bit           take_burst;

   initial begin
      clock = 1'b0;
   end

   always #HALF_PERIOD clock = ~clock;

   function automatic free_rsp_type free_list_update(input logic [OPCODE_BITS-1:0] op,
                                                     input logic [FIELD_BITS-1:0] st,
                                                     input logic [FIELD_BITS-1:0] sz);
      free_rsp_type    r;
      int              pos;
      int              w;
      int              joins;
      logic [FIELD_BITS:0] sum;
      r.status = ST_OK;
      joins = 0;
      if (op == OP_INSERT) begin
         if (free_cnt >= TABLE_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < free_cnt && free_start[pos] < st) pos++;
            for (int k = free_cnt; k > pos; k--) begin
               free_start[k] = free_start[k-1];
               free_size[k]  = free_size[k-1];
            end
            free_start[pos] = st;
            free_size[pos]  = sz;
            free_cnt++;
         end
      end else if (op == OP_DELETE) begin
         pos = 0;
         while (pos < free_cnt && free_start[pos] != st) pos++;
         if (pos >= free_cnt) begin
            r.status = ST_MISSING;
         end else begin
            for (int k = pos; k + 1 < free_cnt; k++) begin
               free_start[k] = free_start[k+1];
               free_size[k]  = free_size[k+1];
            end
            free_cnt--;
         end
      end else if (op == OP_COALESCE && free_cnt >= 2) begin
         w = 0;
         for (int k = 1; k < free_cnt; k++) begin
            sum = {1'b0, free_start[w]} + {1'b0, free_size[w]};
            if (sum == {1'b0, free_start[k]}) begin
               sum = {1'b0, free_size[w]} + {1'b0, free_size[k]};
               free_size[w] = sum[FIELD_BITS] ? '1 : sum[FIELD_BITS-1:0];
               joins++;
            end else begin
               w++;
               free_start[w] = free_start[k];
               free_size[w]  = free_size[k];
            end
         end
         free_cnt = w + 1;
      end
      r.count = free_cnt[COUNT_OUT_BITS-1:0];
      r.joins = joins[JOINS_OUT_BITS-1:0];
      return r;
   endfunction

   function automatic plan_row_type mk_row(input logic [OPCODE_BITS-1:0] op,
                                           input logic [FIELD_BITS-1:0] st,
                                           input logic [FIELD_BITS-1:0] sz,
                                           input bit typed,
                                           input logic [STATUS_BITS-1:0] status,
                                           input int count,
                                           input int joins);
      plan_row_type p;
      p.op         = op;
      p.start      = st;
      p.size       = sz;
      p.typed      = typed;
      p.rsp.status = status;
      p.rsp.count  = count[COUNT_OUT_BITS-1:0];
      p.rsp.joins  = joins[JOINS_OUT_BITS-1:0];
      return p;
   endfunction

   // one request transfer; the prediction is queued at the accepting edge
   task automatic send_item(input logic [OPCODE_BITS-1:0] op,
                            input logic [FIELD_BITS-1:0] st,
                            input logic [FIELD_BITS-1:0] sz,
                            input bit typed,
                            input free_rsp_type typed_rsp);
      int           gap;
      free_rsp_type predicted;
      if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 16);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.block_start <= st;
      req_bus.block_size  <= sz;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = free_list_update(op, st, sz);
      rsp_due.push_back(typed ? typed_rsp : predicted);
      items_sent++;
   endtask

   task automatic send_op(input logic [OPCODE_BITS-1:0] op,
                          input logic [FIELD_BITS-1:0] st,
                          input logic [FIELD_BITS-1:0] sz);
      send_item(op, st, sz, 1'b0, '0);
   endtask

   task automatic report_field(input string name, input int exp_val, input int got_val);
      if (exp_val != got_val) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
         failed = 1'b1;
      end
   endtask

   // response sink with random stalls
   initial begin
      int wait_cycles;
      rsp_bus.ready = 1'b0;
      take_burst = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0) take_burst = !take_burst;
         wait_cycles = take_burst ? 0 : $urandom_range(0, 16);
         if (wait_cycles != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_bus.valid && rsp_bus.ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      free_rsp_type exp_rsp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (rsp_due.size() == 0) begin
            $display("%0t: unexpected response status %0d count %0d joins %0d", $time,
                     rsp_bus.status, rsp_bus.free_count, rsp_bus.joins_made);
            failed = 1'b1;
         end else begin
            exp_rsp = rsp_due.pop_front();
            report_field("status", exp_rsp.status, rsp_bus.status);
            report_field("free_count", exp_rsp.count, rsp_bus.free_count);
            report_field("joins_made", exp_rsp.joins, rsp_bus.joins_made);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [FIELD_BITS-1:0] cs [8];
      logic [FIELD_BITS-1:0] cz [8];
      int                    order [8];
      int                    n;
      int                    j;
      int                    tmp;
      int                    kind;
      int                    next_drain;
      logic [FIELD_BITS-1:0] base;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.opcode      = OP_INSERT;
      req_bus.block_start = '0;
      req_bus.block_size  = '0;
      failed      = 1'b0;
      items_sent  = 0;
      idle_cycles = 0;
      send_burst  = 1'b0;
      free_cnt    = 0;
      next_drain  = DRAIN_EVERY;

      // directed table: empty table, extremes, equal starts, saturation, full
      plan.push_back(mk_row(OP_COALESCE, 32'h0, 32'h0, 1'b1, ST_OK, 0, 0));
      plan.push_back(mk_row(OP_DELETE, 32'h0, 32'h0, 1'b1, ST_MISSING, 0, 0));
      plan.push_back(mk_row(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK, 0, 0));
      plan.push_back(mk_row(OP_INSERT, 32'h0, 32'h0, 1'b1, ST_OK, 1, 0));
      plan.push_back(mk_row(OP_COALESCE, 32'h0, 32'h0, 1'b1, ST_OK, 1, 0));
      plan.push_back(mk_row(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK, 2, 0));
      plan.push_back(mk_row(OP_INSERT, 32'h20, 32'hFFFF_FFF0, 1'b1, ST_OK, 3, 0));
      plan.push_back(mk_row(OP_INSERT, 32'h10, 32'h10, 1'b1, ST_OK, 4, 0));
      plan.push_back(mk_row(OP_INSERT, 32'h10, 32'h4, 1'b1, ST_OK, 5, 0));
      plan.push_back(mk_row(OP_INSERT, 32'hFFFF_FFF0, 32'h20, 1'b1, ST_OK, 6, 0));
      plan.push_back(mk_row(OP_DELETE, 32'h1234, 32'h0, 1'b1, ST_MISSING, 6, 0));
      plan.push_back(mk_row(OP_COALESCE, 32'h0, 32'h0, 1'b0, ST_OK, 0, 0));
      plan.push_back(mk_row(OP_DELETE, 32'h10, 32'h0, 1'b0, ST_OK, 0, 0));
      for (int k = 0; k < 12; k++) begin
         plan.push_back(mk_row(OP_INSERT, 32'h1000 + k * 32'h100, 32'h100, 1'b0, ST_OK, 0, 0));
      end
      plan.push_back(mk_row(OP_INSERT, 32'h5000, 32'h10, 1'b1, ST_FULL, TABLE_DEPTH, 0));
      plan.push_back(mk_row(OP_COALESCE, 32'h0, 32'h0, 1'b0, ST_OK, 0, 0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send_item(plan[i].op, plan[i].start, plan[i].size, plan[i].typed, plan[i].rsp);
      end

      while (items_sent < plan.size() + RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            // chain of touching blocks inserted out of order
            n = $urandom_range(2, 8);
            case ($urandom_range(0, 3))
               0: base = $urandom;
               1: base = 32'hFFFF_FFFF - $urandom_range(0, 32'h1000);
               2: base = $urandom_range(0, 32'h1000);
               default: base = 32'h8000_0000 ^ $urandom_range(0, 32'hFFFF);
            endcase
            for (int k = 0; k < n; k++) begin
               case ($urandom_range(0, 15))
                  0: cz[k] = '0;
                  1: cz[k] = $urandom;
                  default: cz[k] = $urandom_range(1, 256);
               endcase
               cs[k] = (k == 0) ? base : cs[k-1] + cz[k-1];
               order[k] = k;
            end
            for (int k = n - 1; k > 0; k--) begin
               j = $urandom_range(0, k);
               tmp = order[k];
               order[k] = order[j];
               order[j] = tmp;
            end
            while (free_cnt + n > TABLE_DEPTH && $urandom_range(0, 3) != 0) begin
               send_op(OP_DELETE, free_start[$urandom_range(0, free_cnt - 1)], $urandom);
            end
            for (int k = 0; k < n; k++) begin
               send_op(OP_INSERT, cs[order[k]], cz[order[k]]);
               if ($urandom_range(0, 7) == 0) begin
                  send_op(OP_INSERT, cs[$urandom_range(0, n - 1)], $urandom_range(0, 64));
               end
               if ($urandom_range(0, 11) == 0) send_op(OP_COALESCE, $urandom, $urandom);
            end
            if ($urandom_range(0, 3) != 0) send_op(OP_COALESCE, $urandom, $urandom);
         end else if (kind < 8) begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
               if (free_cnt > 0 && $urandom_range(0, 4) != 0) begin
                  send_op(OP_DELETE, free_start[$urandom_range(0, free_cnt - 1)], $urandom);
               end else begin
                  send_op(OP_DELETE, $urandom, $urandom);
               end
            end
         end else begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
               send_op(OPCODE_BITS'($urandom_range(0, 3)), $urandom, $urandom);
            end
         end
         if (items_sent >= next_drain) begin
            // hold off until the response queue is empty
            @(negedge clock);
            req_bus.valid <= 1'b0;
            while (rsp_due.size() != 0) @(negedge clock);
            next_drain += DRAIN_EVERY;
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (!failed) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
